[hw/rtl/ltg_pkg.sv]
// shared constants, codes and types of the toroidal life generation core
// used by every module of the block, depends on nothing else

package ltg_pkg;

   // default store geometry
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   // fixed field widths of the request, response and csr words
   localparam int ROW_SEL_W = 6;
   localparam int CELLS_W   = 64;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   // reset value of both size registers
   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // life rule b3/s23, eight neighbors need a four bit count
   localparam int                   NBR_CNT_W     = 4;
   localparam logic [NBR_CNT_W-1:0] NBR_CNT_BIRTH = 4'd3;
   localparam logic [NBR_CNT_W-1:0] NBR_CNT_KEEP  = 4'd2;

   // one cell and its eight wrapped neighbors
   typedef struct packed {
      logic up_l;
      logic up_c;
      logic up_r;
      logic mid_l;
      logic mid_c;
      logic mid_r;
      logic dn_l;
      logic dn_c;
      logic dn_r;
   } ltg_nbhd_type;

endpackage

[hw/rtl/life_toroidal_generation_core.sv]
// top level of the toroidal life generation core: csr registers, grid memory,
// row sweep sequencer, row window and response registers
// depends on ltg_pkg and ltg_row_unit

// Life B3/S23 on a torus of rows_in_use x cols_in_use cells (counts of 0 act
// as 1, counts above MAX_ROWS/MAX_COLS act as the maximum). A request word is
// taken when start is high and busy is low. A load word (func 0) writes one
// row, masked to the columns in use, and gives no response; rows at or above
// MAX_ROWS are ignored. A step word (func 1) keeps busy high while the grid
// memory, which has one read port, is swept one row per cycle; each row read
// is registered and moves into the row window before its new row is computed.
// Response words come one per cycle, row 0 first, each shown for exactly one
// cycle with rsp_valid high.
// There is no back-pressure: the receiver must take every word as it comes.
// The last word, flagged by rsp_last, shows in the first cycle with busy low, and
// a new request may be given in that same cycle. The grid reads as all dead
// after reset through per-row valid flags, so there is no clearing pass.
// Csr writes are taken at once and must only happen while the core is idle.

module life_toroidal_generation_core #(
   parameter int MAX_ROWS = ltg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = ltg_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [ltg_pkg::ROW_SEL_W-1:0] req_row_select,
   input  logic [ltg_pkg::CELLS_W-1:0]   req_row_cells,
   // response channel
   output logic                          rsp_valid,
   output logic [ltg_pkg::ROW_SEL_W-1:0] rsp_out_row,
   output logic [ltg_pkg::CELLS_W-1:0]   rsp_out_cells,
   output logic                          rsp_row_changed,
   output logic                          rsp_last,
   // csr write port
   input  logic                          csr_we,
   input  logic [ltg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ltg_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int RAW = $clog2(MAX_ROWS);      // row address
   localparam int RCW = $clog2(MAX_ROWS+1);    // row count
   localparam int CCW = $clog2(MAX_COLS+1);    // column count
   localparam int SWW = $clog2(MAX_ROWS+3);    // sweep cycle counter

   // sequencer states
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   // csr registers
   logic [ltg_pkg::CFG_W-1:0] cfg_rows_ff, cfg_cols_ff;
   logic [RCW-1:0]            rows_eff;
   logic [CCW-1:0]            cols_eff;
   logic [MAX_COLS-1:0]       col_mask;

   // sequencer
   logic           state_ff, state_in;
   logic [SWW-1:0] sweep_ff, sweep_in;
   logic           step_go, load_go;
   logic           rd_en, compute_en, last_row;
   logic [RAW-1:0] rd_addr, cur_row;
   logic [RCW-1:0] rows_m1;
   logic [SWW-1:0] sweep_m1, sweep_m3;

   // grid memory and valid flags
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic [MAX_COLS-1:0] mem_q_ff;
   logic                vld_q_ff;
   logic                mem_we;
   logic [RAW-1:0]      mem_waddr;
   logic [MAX_COLS-1:0] mem_wdata;
   logic [MAX_COLS-1:0] rd_row;

   // row window
   logic [MAX_COLS-1:0] up_ff, mid_ff, row0_ff;
   logic [MAX_COLS-1:0] dn_row, new_row;
   logic                changed;

   // response registers
   logic                          rsp_valid_ff;
   logic [ltg_pkg::ROW_SEL_W-1:0] rsp_row_ff;
   logic [ltg_pkg::CELLS_W-1:0]   rsp_cells_ff;
   logic                          rsp_changed_ff;
   logic                          rsp_last_ff;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rows_ff <= ltg_pkg::CFG_SIZE_RESET;
         cfg_cols_ff <= ltg_pkg::CFG_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ltg_pkg::CSR_ROWS_IN_USE: cfg_rows_ff <= csr_wdata;
            ltg_pkg::CSR_COLS_IN_USE: cfg_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, clamp to the store
   always_comb begin
      if (cfg_rows_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (cfg_rows_ff > ltg_pkg::CFG_W'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = cfg_rows_ff[RCW-1:0];
      end
      if (cfg_cols_ff == '0) begin
         cols_eff = CCW'(1);
      end else if (cfg_cols_ff > ltg_pkg::CFG_W'(MAX_COLS)) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = cfg_cols_ff[CCW-1:0];
      end
   end

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
      assign col_mask[j] = (CCW'(j) < cols_eff);
   end

   // ---------------------------------------------------------- sequencer
   assign busy    = (state_ff == ST_SWEEP);
   assign step_go = start && !busy && (req_func == ltg_pkg::FUNC_STEP);
   // loads past the store are dropped
   assign load_go = start && !busy && (req_func == ltg_pkg::FUNC_LOAD)
                 && ({1'b0, req_row_select} < (ltg_pkg::ROW_SEL_W+1)'(MAX_ROWS));

   // sweep cycle s: reads at s = 0..rows, row s-3 computed at s = 3..rows+2
   assign rows_m1    = rows_eff - RCW'(1);
   assign sweep_m1   = sweep_ff - SWW'(1);
   assign sweep_m3   = sweep_ff - SWW'(3);
   assign rd_en      = busy && (sweep_ff <= SWW'(rows_eff));
   assign compute_en = busy && (sweep_ff >= SWW'(3));
   assign last_row   = busy && (sweep_ff == SWW'(rows_eff) + SWW'(2));
   assign cur_row    = sweep_m3[RAW-1:0];

   // first read is the row above row zero, then rows in order
   assign rd_addr = (sweep_ff == '0) ? rows_m1[RAW-1:0] : sweep_m1[RAW-1:0];

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step_go) begin
               state_in = ST_SWEEP;
               sweep_in = '0;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + SWW'(1);
            if (last_row) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // --------------------------------------------------------- grid memory
   // one write port shared by loads and step write-back, one registered read
   assign mem_we    = load_go || compute_en;
   assign mem_waddr = compute_en ? cur_row : req_row_select[RAW-1:0];
   assign mem_wdata = compute_en ? new_row : (req_row_cells[MAX_COLS-1:0] & col_mask);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         mem_q_ff <= grid_mem[rd_addr];
      end
   end

   // never-written rows read as dead
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         vld_q_ff     <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[mem_waddr] <= 1'b1;
         end
         if (rd_en) begin
            vld_q_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // stale columns from a wider count are masked off on read
   assign rd_row = vld_q_ff ? (mem_q_ff & col_mask) : '0;

   // ---------------------------------------------------------- row window
   // old row zero is kept for the last row, whose lower neighbor it is
   always_ff @(posedge clock) begin
      if (busy) begin
         up_ff  <= mid_ff;
         mid_ff <= rd_row;
         if (sweep_ff == SWW'(2)) begin
            row0_ff <= rd_row;
         end
      end
   end

   assign dn_row = last_row ? row0_ff : rd_row;

   ltg_row_unit #(
      .MAX_COLS (MAX_COLS)
   ) u_row_unit (
      .cols_eff (cols_eff),
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .dn_row   (dn_row),
      .new_row  (new_row),
      .changed  (changed)
   );

   // ----------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= compute_en;
      end
   end

   always_ff @(posedge clock) begin
      if (compute_en) begin
         rsp_row_ff     <= ltg_pkg::ROW_SEL_W'(cur_row);
         rsp_cells_ff   <= ltg_pkg::CELLS_W'(new_row);
         rsp_changed_ff <= changed;
         rsp_last_ff    <= last_row;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_cells   = rsp_cells_ff;
   assign rsp_row_changed = rsp_changed_ff;
   assign rsp_last        = rsp_valid_ff && rsp_last_ff;

`ifndef NO_ASSERTIONS
   // a taken step always starts a sweep
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      step_go |=> busy)
      else $error("step word taken but no sweep started");

   // the last word of a generation shows only after the sweep has ended
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> (rsp_valid && !busy))
      else $error("last row shown while sweep still running");

   // rows come back to back and in order until the last one
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && (rsp_out_row == $past(rsp_out_row) + 6'd1)))
      else $error("response rows out of order or gapped");

   // every generation opens with row zero
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> (rsp_out_row == '0))
      else $error("generation did not start at row zero");
`endif

endmodule

[hw/rtl/ltg_lane.sv]
// one cell lane: counts live neighbors and applies the b3/s23 rule
// depends on ltg_pkg for the neighborhood type and rule constants

module ltg_lane (
   input  ltg_pkg::ltg_nbhd_type nbhd,
   output logic                  alive
);

   logic [ltg_pkg::NBR_CNT_W-1:0] count;

   always_comb begin
      count = ltg_pkg::NBR_CNT_W'(nbhd.up_l)  + ltg_pkg::NBR_CNT_W'(nbhd.up_c)
            + ltg_pkg::NBR_CNT_W'(nbhd.up_r)  + ltg_pkg::NBR_CNT_W'(nbhd.mid_l)
            + ltg_pkg::NBR_CNT_W'(nbhd.mid_r) + ltg_pkg::NBR_CNT_W'(nbhd.dn_l)
            + ltg_pkg::NBR_CNT_W'(nbhd.dn_c)  + ltg_pkg::NBR_CNT_W'(nbhd.dn_r);
      alive = (count == ltg_pkg::NBR_CNT_BIRTH)
           || ((count == ltg_pkg::NBR_CNT_KEEP) && nbhd.mid_c);
   end

endmodule

[hw/rtl/ltg_row_unit.sv]
// row unit: wraps the three window rows around the column count, runs one
// lane per column and merges the lanes into the new row and its change flag
// depends on ltg_pkg and ltg_lane

module ltg_row_unit #(
   parameter int MAX_COLS = ltg_pkg::DEF_MAX_COLS
) (
   input  logic [$clog2(MAX_COLS+1)-1:0] cols_eff,
   input  logic [MAX_COLS-1:0]           up_row,
   input  logic [MAX_COLS-1:0]           mid_row,
   input  logic [MAX_COLS-1:0]           dn_row,
   output logic [MAX_COLS-1:0]           new_row,
   output logic                          changed
);

   localparam int CCW = $clog2(MAX_COLS+1);
   localparam int CIW = $clog2(MAX_COLS);

   logic [CCW-1:0]      wrap_full;
   logic [CIW-1:0]      wrap_idx;
   logic [MAX_COLS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
   logic [MAX_COLS-1:0] lane_alive;
   logic [MAX_COLS-1:0] col_in_use;

   // last column in use, left neighbor of column zero
   assign wrap_full = cols_eff - CCW'(1);
   assign wrap_idx  = wrap_full[CIW-1:0];

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      ltg_pkg::ltg_nbhd_type nb;

      assign col_in_use[j] = (CCW'(j) < cols_eff);

      if (j == 0) begin : g_left_wrap
         assign up_l[j]  = up_row[wrap_idx];
         assign mid_l[j] = mid_row[wrap_idx];
         assign dn_l[j]  = dn_row[wrap_idx];
      end else begin : g_left
         assign up_l[j]  = up_row[j-1];
         assign mid_l[j] = mid_row[j-1];
         assign dn_l[j]  = dn_row[j-1];
      end

      if (j == MAX_COLS-1) begin : g_right_wrap
         assign up_r[j]  = up_row[0];
         assign mid_r[j] = mid_row[0];
         assign dn_r[j]  = dn_row[0];
      end else begin : g_right
         // the last column in use wraps to column zero
         assign up_r[j]  = (CCW'(j+1) == cols_eff) ? up_row[0]  : up_row[j+1];
         assign mid_r[j] = (CCW'(j+1) == cols_eff) ? mid_row[0] : mid_row[j+1];
         assign dn_r[j]  = (CCW'(j+1) == cols_eff) ? dn_row[0]  : dn_row[j+1];
      end

      assign nb.up_l  = up_l[j];
      assign nb.up_c  = up_row[j];
      assign nb.up_r  = up_r[j];
      assign nb.mid_l = mid_l[j];
      assign nb.mid_c = mid_row[j];
      assign nb.mid_r = mid_r[j];
      assign nb.dn_l  = dn_l[j];
      assign nb.dn_c  = dn_row[j];
      assign nb.dn_r  = dn_r[j];

      ltg_lane u_lane (
         .nbhd  (nb),
         .alive (lane_alive[j])
      );
   end

   // merge: columns past the count stay dead, compare against the old row
   assign new_row = lane_alive & col_in_use;
   assign changed = (new_row != mid_row);

endmodule
